// ----- rtl/core/sshpd_pkg.sv -----
// sshpd_pkg: types, codes and constants for the ssh packet deframer
// no dependencies; imported by ssh_packet_deframer
`default_nettype none

package sshpd_pkg;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_BODY = 2'd1,
    PH_MAC  = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_LEN  = 2'd0;
  localparam logic [1:0] KIND_BODY = 2'd1;
  localparam logic [1:0] KIND_MAC  = 2'd2;
  localparam logic [1:0] KIND_DROP = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_LARGE   = 2'd1;
  localparam logic [1:0] ERR_INVALID = 2'd2;

  localparam logic [1:0] CFG_LENGTH_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SIZE_LOG2 = 2'd1;
  localparam logic [1:0] CFG_MAC_SIZE        = 2'd2;

  localparam logic [31:0] MIN_LENGTH     = 32'd12;
  localparam logic [31:0] MIN_LENGTH_32B = 32'd28;
  localparam logic [4:0]  LEN_BYTES      = 5'd4;
  localparam logic [1:0]  LAST_LEN_IDX   = 2'd3;

  localparam logic [31:0] LIMIT_RESET    = 32'd35000;
  localparam logic [2:0]  BLOCK_LG_RESET = 3'd3;
  localparam logic [6:0]  MAC_RESET      = 7'd0;

  localparam logic [4:0]  MASK_32B       = 5'd31;

  // block size minus one, with log2 clamped to 3..5
  function automatic logic [4:0] block_mask(input logic [2:0] lg);
    logic [4:0] m;
    case (lg) inside
      [3'd0:3'd3]: m = 5'd7;
      3'd4:        m = 5'd15;
      default:     m = MASK_32B;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ssh_packet_deframer.sv -----
// ssh_packet_deframer: splits a decrypted byte stream into ssh binary packets
// depends on sshpd_pkg
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_data_byte
// out      output     out_valid / out_stall out_byte, out_byte_kind, out_last_of_packet,
//                                          out_packet_seq, out_packet_length, out_error_code
// cfg      input      cfg_we               cfg_index, cfg_data
//
// one beat per cycle while in_stall is low; each beat's result is registered and appears the cycle after it is taken
// the limit is the single output register: a new beat is taken while it drains
// in_stall is high only while a result waits and out_stall holds it
// rst_n is synchronous; reset clears phase, counts, sequence, error and output valid
// a length error is sticky until reset; later beats come out as discarded
`default_nettype none

module ssh_packet_deframer
  import sshpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_byte_kind,
  output logic             out_last_of_packet,
  output logic [31:0]      out_packet_seq,
  output logic [31:0]      out_packet_length,
  output logic [1:0]       out_error_code
);

  logic [31:0] length_limit_r;
  logic [2:0]  block_lg_r;
  logic [6:0]  mac_size_r;

  phase_t      phase_r, phase_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic [1:0]  kind_r, kind_nxt;
  logic        last_r, last_nxt;
  logic [31:0] pseq_r, pseq_nxt;
  logic [31:0] plen_r, plen_nxt;

  logic        accept;
  logic [31:0] count_inc;
  logic [31:0] len_shift;
  logic [4:0]  mask;
  logic [4:0]  low_sum;
  logic        over_limit;
  logic        invalid;
  logic [1:0]  check;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_limit_r <= LIMIT_RESET;
      block_lg_r     <= BLOCK_LG_RESET;
      mac_size_r     <= MAC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LENGTH_LIMIT:    length_limit_r <= cfg_data;
        CFG_BLOCK_SIZE_LOG2: block_lg_r     <= cfg_data[2:0];
        CFG_MAC_SIZE:        mac_size_r     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // length check on the assembled length word
  assign count_inc  = count_r + 32'd1;
  assign len_shift  = {len_r[23:0], in_data_byte};
  assign mask       = block_mask(block_lg_r);
  assign low_sum    = len_shift[4:0] + LEN_BYTES;
  assign over_limit = len_shift > length_limit_r;
  assign invalid    = (len_shift < MIN_LENGTH) ||
                      ((mask == MASK_32B) && (len_shift < MIN_LENGTH_32B)) ||
                      ((low_sum & mask) != 5'd0);
  assign check      = over_limit ? ERR_LARGE : (invalid ? ERR_INVALID : ERR_NONE);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    err_nxt   = err_r;
    kind_nxt  = KIND_DROP;
    last_nxt  = 1'b0;
    pseq_nxt  = seq_r;
    plen_nxt  = len_r;
    case (phase_r)
      PH_LEN: begin
        kind_nxt  = KIND_LEN;
        len_nxt   = len_shift;
        count_nxt = count_inc;
        plen_nxt  = 32'd0;
        if (count_r[1:0] == LAST_LEN_IDX) begin
          plen_nxt  = len_shift;
          count_nxt = 32'd0;
          if (check != ERR_NONE) begin
            err_nxt   = check;
            phase_nxt = PH_ERR;
          end else begin
            seq_nxt   = seq_r + 32'd1;
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        kind_nxt  = KIND_BODY;
        pseq_nxt  = seq_r - 32'd1;
        count_nxt = count_inc;
        if (count_inc >= len_r) begin
          count_nxt = 32'd0;
          if (mac_size_r == 7'd0) begin
            last_nxt  = 1'b1;
            len_nxt   = 32'd0;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_MAC;
          end
        end
      end
      PH_MAC: begin
        kind_nxt  = KIND_MAC;
        pseq_nxt  = seq_r - 32'd1;
        count_nxt = count_inc;
        if (count_inc >= {25'd0, mac_size_r}) begin
          last_nxt  = 1'b1;
          count_nxt = 32'd0;
          len_nxt   = 32'd0;
          phase_nxt = PH_LEN;
        end
      end
      default: begin
        kind_nxt = KIND_DROP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN;
      count_r     <= 32'd0;
      len_r       <= 32'd0;
      seq_r       <= 32'd0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        len_r   <= len_nxt;
        seq_r   <= seq_nxt;
        err_r   <= err_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register payload
  logic [1:0] oerr_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
      kind_r <= kind_nxt;
      last_r <= last_nxt;
      pseq_r <= pseq_nxt;
      plen_r <= plen_nxt;
      oerr_r <= err_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = byte_r;
  assign out_byte_kind      = kind_r;
  assign out_last_of_packet = last_r;
  assign out_packet_seq     = pseq_r;
  assign out_packet_length  = plen_r;
  assign out_error_code     = oerr_r;

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERR |=> phase_r == PH_ERR)
    else $error("error phase left without reset");

  a_drop_has_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == KIND_DROP) |-> oerr_r != ERR_NONE)
    else $error("discarded beat without latched error");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> (kind_r == KIND_BODY) || (kind_r == KIND_MAC))
    else $error("end of packet on a length or discarded beat");

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (phase_r == PH_LEN) && (phase_nxt == PH_BODY) |=> seq_r == $past(seq_r) + 32'd1)
    else $error("sequence number did not advance on accepted length");

endmodule

`default_nettype wire
